/* hdl/ptsa_pkg.sv */
`default_nettype none

package ptsa_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 8;

	localparam int LEVEL_W = 3;
	localparam int TP_W    = 16;
	localparam int TAG_W   = 8;

	typedef enum logic {
		OP_ACQUIRE = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		KIND_GRANTED   = 3'd0,
		KIND_REFUSED   = 3'd1,
		KIND_EVICTED   = 3'd2,
		KIND_RELEASED  = 3'd3,
		KIND_NOT_FOUND = 3'd4,
		KIND_FULL      = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK,
		ST_PACK,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t                op;
		logic [LEVEL_W-1:0] level;
		logic [TP_W-1:0]    transponder;
		logic [TAG_W-1:0]   release_tag;
		logic               notify;
	} req_t;

	typedef struct packed {
		kind_t            kind;
		logic [TAG_W-1:0] tag;
		logic             switch_needed;
		logic             now_empty;
		logic             owner_notice;
		logic             last;
	} res_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [TP_W-1:0]    transponder;
		logic [TAG_W-1:0]   tag;
	} entry_t;

	typedef struct packed {
		logic   en;
		entry_t data;
	} mem_wr_t;

endpackage

`default_nettype wire

/* hdl/ptsa_store.sv */
`default_nettype none

// Subscription table storage: one write port, one read port, registered read data.
module ptsa_store import ptsa_pkg::*; #(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire mem_wr_t          wr,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_addr,
	output entry_t                rd_data
);

	entry_t mem_q [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr_addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* hdl/preemptive_tuner_share_arbiter.sv */
`default_nettype none

// Channel   | Signals                    | Transfer
// ----------+----------------------------+-------------------------------------------
// request   | start, busy, req           | at a rising edge with start high, busy low
// result    | result_strobe, result      | every cycle result_strobe is high
// config    | cfg_we, cfg_wdata          | at a rising edge with cfg_we high
//
// An acquire holds busy high while it works through the table. A scan pass over the
// table memory decides refusal, evictions and the full case, a decision state acts on
// that decision, a second pass reports evictions and compacts the survivors, one entry
// per cycle through the single read port, and a last state appends the new entry. A
// refused or full acquire ends after the decision state. A release makes one compacting
// pass and then takes the final state. Results leave through an output register in the
// cycle after they are formed, and the receiver cannot stall them. Reset clears the
// entry count, the tag counter and the live level; the table contents need no clearing
// since only entries below the count are ever read.
module preemptive_tuner_share_arbiter import ptsa_pkg::*; #(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire req_t               req,
	output logic                    result_strobe,
	output res_t                    result,
	input  wire logic               cfg_we,
	input  wire logic [LEVEL_W-1:0] cfg_wdata
);

	state_t state_q, state_d;

	// Control state, cleared by reset.
	logic [CNT_W-1:0]   count_q;
	logic [TAG_W-1:0]   next_tag_q;
	logic [LEVEL_W-1:0] live_q;
	logic               rvalid_s1;
	logic               res_vld_q;

	// Per-request working registers; all but ridx_s1 and res_q are initialized when a request transfer happens.
	req_t               req_q;
	logic [CNT_W-1:0]   rd_q;
	logic [IDX_W-1:0]   ridx_s1;
	logic               refuse_q;
	logic               stop_q;
	logic               sw_q;
	logic [TABLE_DEPTH-1:0] mark_q;
	logic [CNT_W-1:0]   nmark_q;
	logic [CNT_W-1:0]   keep_q;
	logic               found_q;
	res_t               res_q;

	logic             accept;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	mem_wr_t          wr;
	logic [IDX_W-1:0] wr_addr;
	entry_t           rd_data;
	logic             live;
	logic             full;
	logic             rel_match;
	logic             keep_entry;
	logic             res_vld_d;
	res_t             res_d;

	ptsa_store #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr      (wr),
		.wr_addr (wr_addr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// A live request preempts entries on its own transponder as well.
	assign live = (req_q.level == live_q);

	// Table stays full after the marked entries leave: nothing may change.
	assign full = ((count_q - nmark_q) >= CNT_W'(TABLE_DEPTH));

	// During a release the first entry carrying the tag is the one dropped.
	assign rel_match  = !found_q && (rd_data.tag == req_q.release_tag);
	assign keep_entry = (req_q.op == OP_ACQUIRE) ? !mark_q[ridx_s1] : !rel_match;

	// Both passes stream the table from index zero up to the entry count.
	assign rd_en   = ((state_q == ST_SCAN) || (state_q == ST_PACK)) && (rd_q < count_q);
	assign rd_addr = rd_q[IDX_W-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (req.op == OP_ACQUIRE) ? ST_SCAN : ST_PACK;
				end
			end
			ST_SCAN: begin
				if (!rd_en && !rvalid_s1) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = (refuse_q || full) ? ST_IDLE : ST_PACK;
			end
			ST_PACK: begin
				if (!rd_en && !rvalid_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		wr        = '0;
		wr_addr   = keep_q[IDX_W-1:0];
		res_vld_d = 1'b0;
		res_d     = '0;
		case (state_q)
			ST_CHECK: begin
				// A more urgent holder wins over everything else.
				if (refuse_q) begin
					res_vld_d  = 1'b1;
					res_d.kind = KIND_REFUSED;
					res_d.last = 1'b1;
				end else if (full) begin
					res_vld_d  = 1'b1;
					res_d.kind = KIND_FULL;
					res_d.last = 1'b1;
				end
			end
			ST_PACK: begin
				if (rvalid_s1) begin
					// Survivors slide down to the next free slot, which is never ahead
					// of the entry being read, so no unread entry is overwritten.
					if (keep_entry) begin
						wr.en   = 1'b1;
						wr.data = rd_data;
					end else if (req_q.op == OP_ACQUIRE) begin
						res_vld_d          = 1'b1;
						res_d.kind         = KIND_EVICTED;
						res_d.tag          = rd_data.tag;
						res_d.owner_notice = 1'b1;
					end
				end
			end
			ST_DONE: begin
				res_vld_d  = 1'b1;
				res_d.last = 1'b1;
				if (req_q.op == OP_ACQUIRE) begin
					wr.en                = 1'b1;
					wr.data.level        = req_q.level;
					wr.data.transponder  = req_q.transponder;
					wr.data.tag          = next_tag_q;
					res_d.kind           = KIND_GRANTED;
					res_d.tag            = next_tag_q;
					res_d.switch_needed  = sw_q;
				end else begin
					// After the pass, the kept count is the new table size.
					res_d.tag       = req_q.release_tag;
					res_d.now_empty = (keep_q == '0);
					if (found_q) begin
						res_d.kind         = KIND_RELEASED;
						res_d.owner_notice = req_q.notify;
					end else begin
						res_d.kind = KIND_NOT_FOUND;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			next_tag_q <= '0;
			live_q     <= '0;
			rvalid_s1  <= 1'b0;
			res_vld_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rvalid_s1 <= rd_en;
			res_vld_q <= res_vld_d;
			if (cfg_we) begin
				live_q <= cfg_wdata;
			end
			if (state_q == ST_DONE) begin
				if (req_q.op == OP_ACQUIRE) begin
					count_q    <= keep_q + CNT_W'(1);
					next_tag_q <= next_tag_q + TAG_W'(1);
				end else begin
					count_q <= keep_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= rd_addr;
		res_q   <= res_d;
		if (accept) begin
			req_q    <= req;
			rd_q     <= '0;
			refuse_q <= 1'b0;
			stop_q   <= 1'b0;
			sw_q     <= 1'b1;
			mark_q   <= '0;
			nmark_q  <= '0;
			keep_q   <= '0;
			found_q  <= 1'b0;
		end else begin
			if (state_q == ST_CHECK) begin
				rd_q <= '0;
			end else if (rd_en) begin
				rd_q <= rd_q + CNT_W'(1);
			end
			if (rvalid_s1 && (state_q == ST_SCAN)) begin
				if (rd_data.level < req_q.level) begin
					refuse_q <= 1'b1;
				end
				// The first same-transponder holder ends the eviction search,
				// unless the request is live.
				if (!stop_q) begin
					if ((rd_data.transponder != req_q.transponder) || live) begin
						if (rd_data.level > req_q.level) begin
							mark_q[ridx_s1] <= 1'b1;
							nmark_q         <= nmark_q + CNT_W'(1);
						end
					end else begin
						stop_q <= 1'b1;
						sw_q   <= 1'b0;
					end
				end
			end
			if (rvalid_s1 && (state_q == ST_PACK)) begin
				if (keep_entry) begin
					keep_q <= keep_q + CNT_W'(1);
				end
				if ((req_q.op == OP_RELEASE) && rel_match) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	assign result_strobe = res_vld_q;
	assign result        = res_q;

	// The table never holds more entries than it has slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count exceeds table depth");

	// Compaction never writes the slot that is being read in the same cycle.
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.en && rd_en) |-> (wr_addr != rd_addr))
		else $error("table read and write hit the same slot");

	// Evictions can only come from entries that are in the table.
	a_marks_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> (nmark_q <= count_q))
		else $error("more evictions than entries");

	// The final result of a request goes out once the controller is idle again.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.last) |-> !busy)
		else $error("final result while still busy");

	// A request transfer always starts work.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("request taken but controller stayed idle");

endmodule

`default_nettype wire

/* test/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ptsa_pkg::*;

	localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
	// Longest legal stretch without any transfer: a settle pause before a register
	// write, a full acquire over a packed table and the longest sender gap all fit
	// many times over into this many cycles.
	localparam int STALL_LIMIT = 1000;
	// Cycles allowed after the last expected result before a register write or the
	// end of the run. It covers a full acquire over a packed table and the output stage.
	localparam int SETTLE_CYCLES = 30;

	// The subscription table as the block should hold it. Every accepted request is
	// applied here at once, and the results it must cause are queued in order.
	class tuner_share_model;
		entry_t      slots[TABLE_DEPTH];
		int unsigned fill;
		logic [7:0]  tag_ctr;
		logic [2:0]  live_lvl;
		res_t        due_results[$];
		int unsigned errors;
		int unsigned requests;
		int unsigned grants;
		int unsigned evictions;
		int unsigned refusals;
		int unsigned fulls;
		int unsigned releases;
		int unsigned misses;
		int unsigned tag_wraps;
		int unsigned most_results;

		function new();
			fill = 0;
			tag_ctr = '0;
			live_lvl = '0;
		endfunction

		function void queue_result(kind_t k, logic [7:0] t, logic sw, logic empty,
				logic notice, logic fin);
			res_t r;
			r.kind = k;
			r.tag = t;
			r.switch_needed = sw;
			r.now_empty = empty;
			r.owner_notice = notice;
			r.last = fin;
			due_results = {due_results, r};
		endfunction

		function void acquire(logic [2:0] lv, logic [15:0] tp);
			logic [TABLE_DEPTH-1:0] doomed;
			int unsigned n_doomed;
			int unsigned keep;
			logic sw;
			logic live;
			doomed = '0;
			n_doomed = 0;
			keep = 0;
			sw = 1'b1;
			live = (lv == live_lvl);
			for (int i = 0; i < fill; i++) begin
				if (slots[i].level < lv) begin
					refusals++;
					queue_result(KIND_REFUSED, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
					return;
				end
			end
			// Walk the table until a non-live request meets its own transponder.
			for (int i = 0; i < fill; i++) begin
				if (slots[i].transponder != tp || live) begin
					if (slots[i].level > lv) begin
						doomed[i] = 1'b1;
						n_doomed++;
					end
				end else begin
					sw = 1'b0;
					break;
				end
			end
			if (fill - n_doomed >= TABLE_DEPTH) begin
				fulls++;
				queue_result(KIND_FULL, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
				return;
			end
			for (int i = 0; i < fill; i++) begin
				if (doomed[i]) begin
					evictions++;
					queue_result(KIND_EVICTED, slots[i].tag, 1'b0, 1'b0, 1'b1, 1'b0);
				end else begin
					slots[keep] = slots[i];
					keep++;
				end
			end
			slots[keep] = '{level: lv, transponder: tp, tag: tag_ctr};
			fill = keep + 1;
			grants++;
			queue_result(KIND_GRANTED, tag_ctr, sw, 1'b0, 1'b0, 1'b1);
			tag_ctr++;
			if (tag_ctr == 8'h00)
				tag_wraps++;
		endfunction

		function void release_entry(logic [7:0] t, logic nt);
			for (int i = 0; i < fill; i++) begin
				if (slots[i].tag == t) begin
					for (int j = i + 1; j < fill; j++)
						slots[j - 1] = slots[j];
					fill--;
					releases++;
					queue_result(KIND_RELEASED, t, 1'b0, fill == 0, nt, 1'b1);
					return;
				end
			end
			misses++;
			queue_result(KIND_NOT_FOUND, t, 1'b0, fill == 0, 1'b0, 1'b1);
		endfunction

		function void note_request(req_t r);
			int unsigned queued;
			queued = due_results.size();
			requests++;
			if (r.op == OP_ACQUIRE)
				acquire(r.level, r.transponder);
			else
				release_entry(r.release_tag, r.notify);
			if (due_results.size() - queued > most_results)
				most_results = due_results.size() - queued;
		endfunction

		function void compare_field(string field, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				errors++;
				$error("%s mismatch: expected %0d, got %0d", field, want, got);
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (due_results.size() == 0) begin
				errors++;
				$error("unexpected result: kind %0d tag %0d", got.kind, got.tag);
				return;
			end
			want = due_results.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("tag", want.tag, got.tag);
			compare_field("switch_needed", want.switch_needed, got.switch_needed);
			compare_field("now_empty", want.now_empty, got.now_empty);
			compare_field("owner_notice", want.owner_notice, got.owner_notice);
			compare_field("last", want.last, got.last);
		endfunction

		function logic [2:0] min_level();
			logic [2:0] m;
			m = 3'd7;
			for (int i = 0; i < fill; i++)
				if (slots[i].level < m)
					m = slots[i].level;
			return m;
		endfunction

		function int unsigned tag_count(logic [7:0] t);
			int unsigned c;
			c = 0;
			for (int i = 0; i < fill; i++)
				if (slots[i].tag == t)
					c++;
			return c;
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	req_t               req;
	logic               result_strobe;
	res_t               result;
	logic               cfg_we;
	logic [LEVEL_W-1:0] cfg_wdata;

	tuner_share_model model;
	logic [15:0]      tp_pool[4];
	logic             back_to_back;
	logic [2:0]       mid_live;
	int unsigned      moves;
	int unsigned      moves_seen;
	int unsigned      stalled;

	preemptive_tuner_share_arbiter #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.result_strobe(result_strobe),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A result transfer happens at every edge that ends a cycle with the strobe
	// high. Outputs are read right after the edge, so they are the values that
	// the block held going into it.
	always @(posedge clk) begin
		if (arst_n && model != null && result_strobe === 1'b1) begin
			model.check_result(result);
			moves++;
		end
	end

	// The watchdog ends the run when no transfer of any kind has happened for
	// too long, which covers a hung block and results that never arrive.
	always @(posedge clk) begin
		if (moves != moves_seen) begin
			moves_seen = moves;
			stalled = 0;
		end else begin
			stalled++;
		end
		if (stalled >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Unused fields of each request carry random bits, so the block is also
	// shown that it must ignore them.
	function automatic req_t make_acquire(logic [2:0] lv, logic [15:0] tp);
		logic [$bits(req_t)-1:0] raw;
		req_t r;
		raw = $urandom;
		r = raw;
		r.op = OP_ACQUIRE;
		r.level = lv;
		r.transponder = tp;
		return r;
	endfunction

	function automatic req_t make_release(logic [7:0] t, logic nt);
		logic [$bits(req_t)-1:0] raw;
		req_t r;
		raw = $urandom;
		r = raw;
		r.op = OP_RELEASE;
		r.release_tag = t;
		r.notify = nt;
		return r;
	endfunction

	// Transponders are mostly drawn from those already in the table or from a
	// small pool, since matches are what end the eviction search early.
	function automatic logic [15:0] pick_tp();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 4 && model.fill != 0)
			return model.slots[$urandom_range(0, model.fill - 1)].transponder;
		if (roll < 7)
			return tp_pool[$urandom_range(0, 3)];
		return 16'($urandom);
	endfunction

	// Offers one request and returns at the edge where its transfer happens. The
	// sender may hold start low before each request, except during stretches
	// of back-to-back traffic. With no wait, start simply stays high.
	task automatic issue(input req_t r);
		int unsigned gap;
		if ($urandom_range(0, 24) == 0)
			back_to_back = ~back_to_back;
		gap = back_to_back ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy !== 1'b0);
		model.note_request(r);
		moves++;
	endtask

	// Brings the block to rest: no request offered, every result in, and some
	// margin for the block to return to idle.
	task automatic settle();
		start <= 1'b0;
		while (model.due_results.size() != 0 || busy !== 1'b0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_live_level(input logic [2:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		model.live_lvl = v;
		moves++;
		cfg_we <= 1'b0;
	endtask

	// Hand-picked requests: a miss on the empty table, same and other transponder
	// grants, an eviction search cut short by a same-transponder entry, a refusal, a live
	// grab at the reset level, a release that empties the table, a full table, and
	// after the live level moves, a live grant on its own transponder, a full case
	// where the eviction search stops at once, and an acquire that evicts every entry.
	task automatic run_directed();
		issue(make_release(8'h00, 1'b1));
		issue(make_acquire(3'd7, 16'h0000));
		issue(make_acquire(3'd7, 16'h0000));
		issue(make_acquire(3'd7, 16'hFFFF));
		issue(make_acquire(3'd5, 16'hFFFF));
		issue(make_acquire(3'd6, 16'h1234));
		issue(make_acquire(3'd0, 16'h8001));
		issue(make_release(model.slots[0].tag, 1'b0));
		issue(make_release(8'hFF, 1'b1));
		for (int i = 0; i < TABLE_DEPTH; i++)
			issue(make_acquire(3'd4, 16'(16'h1111 * (i + 1))));
		issue(make_acquire(3'd4, 16'hABCD));
		issue(make_release(8'hFF, 1'b0));
		issue(make_release(model.slots[3].tag, 1'b1));
		write_live_level(3'd4);
		issue(make_acquire(3'd4, model.slots[0].transponder));
		issue(make_acquire(3'd3, model.slots[0].transponder));
		issue(make_acquire(3'd3, 16'hFFFF));
		issue(make_acquire(3'd7, 16'h5555));
		issue(make_release(model.slots[0].tag, 1'b1));
	endtask

	// Mixed traffic. Half of the acquires are made urgent enough to pass the
	// refusal check, so that evictions and full tables come up often; most
	// releases name a tag that is really in the table.
	task automatic run_mixed(input int unsigned count);
		logic [7:0] t;
		logic [2:0] lv;
		for (int n = 0; n < count; n++) begin
			if (model.fill != 0 && $urandom_range(0, 99) < 40) begin
				if ($urandom_range(0, 99) < 85)
					t = model.slots[$urandom_range(0, model.fill - 1)].tag;
				else
					t = 8'($urandom);
				issue(make_release(t, 1'($urandom)));
			end else begin
				if ($urandom_range(0, 1) == 1)
					lv = 3'($urandom_range(0, model.min_level()));
				else
					lv = 3'($urandom);
				issue(make_acquire(lv, pick_tp()));
			end
		end
	endtask

	// Tag reuse needs one entry to live through 256 grants. An anchor at level 3
	// sits at the head of the table; later acquires are at its level, less urgent, or
	// more urgent on its own transponder where the eviction search stops at the anchor,
	// so it is never evicted. Other entries are released as they pile up. Once a grant
	// hands out the anchor's tag again, two releases of that tag must remove the
	// anchor first and then the newer entry.
	task automatic run_tag_reuse();
		logic [15:0] home_tp;
		logic [7:0]  anchor;
		logic [7:0]  t;
		int unsigned roll;
		int unsigned guard;
		while (model.fill != 0)
			issue(make_release(model.slots[0].tag, 1'($urandom)));
		home_tp = 16'($urandom);
		anchor = model.tag_ctr;
		issue(make_acquire(3'd3, home_tp));
		guard = 0;
		while (model.tag_count(anchor) < 2 && guard < 3000) begin
			guard++;
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				t = 8'($urandom);
				if (t == anchor)
					t = ~t;
				issue(make_release(t, 1'($urandom)));
			end else if (roll < 8) begin
				issue(make_acquire(3'd7, pick_tp()));
			end else if (roll < 18) begin
				issue(make_acquire(3'($urandom_range(1, 2)), home_tp));
			end else begin
				issue(make_acquire(3'd3, pick_tp()));
			end
			if (model.tag_count(anchor) < 2)
				while (model.fill > 1 + $urandom_range(0, 1))
					issue(make_release(model.slots[$urandom_range(1, model.fill - 1)].tag,
						1'($urandom)));
		end
		issue(make_release(anchor, 1'b1));
		issue(make_release(anchor, 1'b0));
		while (model.fill != 0)
			issue(make_release(model.slots[0].tag, 1'($urandom)));
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		back_to_back = 1'b0;
		moves = 0;
		moves_seen = 0;
		stalled = 0;
		model = new();
		tp_pool[0] = 16'h0000;
		tp_pool[1] = 16'hFFFF;
		tp_pool[2] = 16'($urandom);
		tp_pool[3] = 16'($urandom);
		mid_live = 3'($urandom_range(1, 6));
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The directed part starts on the reset value of the live level.
		run_directed();
		write_live_level(3'd7);
		run_mixed(125);
		write_live_level(mid_live);
		run_mixed(125);
		write_live_level(3'd0);
		run_tag_reuse();

		// Drain: every expected result must arrive, and nothing may follow it.
		start <= 1'b0;
		while (model.due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d requests at live levels 0, 4, 7 and %0d:",
			model.requests, mid_live);
		$display("%0d grants, %0d evictions, %0d refusals, %0d full tables,",
			model.grants, model.evictions, model.refusals, model.fulls);
		$display("%0d releases, %0d misses, %0d tag wraps, max %0d results",
			model.releases, model.misses, model.tag_wraps, model.most_results);
		if (model.errors == 0 && model.due_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
